// ===== rtl/core/pfap_pkg.sv =====
package pfap_pkg;

	localparam int AXES_DEF   = 4;
	localparam int VAL_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int DT_W       = 16;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int GAIN_SLOTS = 4;
	// Derivative numerator: 16-bit gain times 33-bit difference, shifted by 8.
	localparam int NUM_W      = 57;
	localparam int QUO_W      = 57;

	localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV = 2'd2;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_OUT  = 5'b10000
	} lane_state_t;

	typedef struct packed {
		logic start;
		logic clear;
	} lane_ctl_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] mx;
		logic signed [63:0] mn;
		mx = 64'sd2147483647;
		mn = -64'sd2147483648;
		if (v > mx)
			return 32'sh7fffffff;
		else if (v < mn)
			return 32'sh80000000;
		else
			return v[VAL_W-1:0];
	endfunction

endpackage

// ===== rtl/core/pfap_lane.sv =====
module pfap_lane import pfap_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lane_ctl_t               ctl,
	input  logic signed [VAL_W-1:0] ref_val,
	input  logic signed [VAL_W-1:0] meas_val,
	input  logic [DT_W-1:0]         dt,
	input  logic [GAIN_W-1:0]       kp,
	input  logic [GAIN_W-1:0]       ki,
	input  logic [GAIN_W-1:0]       kd,
	output logic                    done,
	output logic signed [VAL_W-1:0] drive
);

	lane_state_t state_q;
	logic signed [VAL_W-1:0] integ_q, prev_q, err_q;
	logic [DT_W-1:0]         dt_q;
	logic signed [48:0]      p_q;
	logic signed [48:0]      ke_q;
	logic signed [49:0]      kdd_q;
	logic signed [63:0]      inc_q;
	logic                    neg_q;
	logic [NUM_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [5:0]              cnt_q;
	logic                    ctl_clr_q;

	logic signed [VAL_W:0] diff;
	logic signed [VAL_W:0] err_full;
	logic signed [VAL_W-1:0] err_c;
	logic [NUM_W:0]        trial;
	logic signed [63:0]    d_val;
	logic signed [63:0]    isum;

	assign err_full = {ref_val[VAL_W-1], ref_val} - {meas_val[VAL_W-1], meas_val};
	assign err_c    = sat32(64'(err_full));
	assign diff     = {err_q[VAL_W-1], err_q} - {prev_q[VAL_W-1], prev_q};
	assign trial    = {rem_q, quo_q[QUO_W-1]} - {{(NUM_W-DT_W+1){1'b0}}, dt_q};
	assign d_val    = neg_q ? -$signed(64'(quo_q)) : $signed(64'(quo_q));
	assign isum     = 64'(integ_q) + (inc_q >>> 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			integ_q <= '0;
			prev_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start && ctl.clear) begin
						integ_q <= '0;
						prev_q  <= '0;
						state_q <= ST_OUT;
					end else if (ctl.start) begin
						err_q   <= err_c;
						dt_q    <= dt;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					p_q     <= $signed({1'b0, kp}) * err_q;
					ke_q    <= $signed({1'b0, ki}) * err_q;
					kdd_q   <= $signed({1'b0, kd}) * diff;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					inc_q   <= 64'(ke_q) * $signed({1'b0, dt_q});
					neg_q   <= kdd_q[49];
					rem_q   <= '0;
					quo_q   <= kdd_q[49] ? 57'(-64'(kdd_q)) << 8 : 57'(64'(kdd_q)) << 8;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// One quotient bit per cycle, restoring division.
					if (!trial[NUM_W]) begin
						rem_q <= trial[NUM_W-1:0];
						quo_q <= {quo_q[QUO_W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[NUM_W-2:0], quo_q[QUO_W-1]};
						quo_q <= {quo_q[QUO_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(QUO_W - 1)) begin
						state_q <= ST_OUT;
						integ_q <= sat32(isum);
						prev_q  <= err_q;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Drive computed on the final cycle once the quotient and integral are in.
	logic signed [63:0] total;
	assign total = (p_q >>> 8) + 64'(integ_q) + ((dt_q == '0) ? 64'sd0 : d_val);

	assign done  = (state_q == ST_OUT);
	assign drive = ctl_clr_q ? '0 : sat32(total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_clr_q <= 1'b0;
		else if (state_q == ST_IDLE && ctl.start)
			ctl_clr_q <= ctl.clear;
	end

	property p_done_after_div;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_DIV && cnt_q == 6'(QUO_W - 1))
			|=> done;
	endproperty
	assert property (p_done_after_div) else $error("lane did not finish after division");

	property p_clear_zeroes;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_IDLE && ctl.start && ctl.clear)
			|=> (integ_q == '0 && prev_q == '0);
	endproperty
	assert property (p_clear_zeroes) else $error("clear did not zero lane state");

	property p_div_count;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_DIV) |-> (cnt_q == '0 ||
			state_q == ST_OUT || state_q == ST_IDLE || state_q == ST_MUL || state_q == ST_PREP);
	endproperty
	assert property (p_div_count) else $error("division counter out of step");

endmodule

// ===== rtl/core/pfap_merge.sv =====
module pfap_merge import pfap_pkg::*; #(
	parameter int AXES = AXES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [AXES-1:0]                   lane_done,
	input  logic [AXES-1:0][VAL_W-1:0]        lane_drive,
	input  logic                              take,
	output logic                              full,
	output logic [AXES-1:0][VAL_W-1:0]        result
);

	logic full_q;
	logic [AXES-1:0][VAL_W-1:0] result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			full_q <= 1'b0;
		else if (&lane_done)
			full_q <= 1'b1;
		else if (take)
			full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (&lane_done)
			result_q <= lane_drive;
	end

	assign full   = full_q;
	assign result = result_q;

	property p_lanes_together;
		@(posedge clk) disable iff (!arst_n) (|lane_done) |-> (&lane_done);
	endproperty
	assert property (p_lanes_together) else $error("lanes finished out of step");

	property p_no_overwrite;
		@(posedge clk) disable iff (!arst_n) (&lane_done) |-> (!full_q || take);
	endproperty
	assert property (p_no_overwrite) else $error("result overwritten before taken");

	property p_hold;
		@(posedge clk) disable iff (!arst_n) (full_q && !take && !(&lane_done)) |=> full_q;
	endproperty
	assert property (p_hold) else $error("result dropped");

endmodule

// ===== rtl/core/pid_four_axis_position.sv =====
// Channel  | Ports                           | Word
// s_axis   | s_tvalid s_tready s_tdata s_tuser| refs, meas, step_time; tuser opcode
// m_axis   | m_tvalid m_tready m_tdata        | drive per axis
// cfg      | cfg_we cfg_idx cfg_wdata        | gain registers, no read-back
//
// From acceptance to result a word goes through: latching the error, the gain
// multiplies, the integral product, a bit-serial divide to a 57-bit quotient
// in every lane, and the output state, which hands over the result. A clear word
// goes straight to the output. Reset clears the integral and previous error.
// A new word is accepted once the lanes are idle and the output register is free.
module pid_four_axis_position import pfap_pkg::*; #(
	parameter int AXES = AXES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// ref axes 0..AXES-1, meas axes 0..AXES-1, step_time, from bit 0 up
	input  logic [((2*AXES*VAL_W+DT_W+7)/8)*8-1:0] s_tdata,
	// opcode
	input  logic                       s_tuser,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// drive axes 0..AXES-1 from bit 0 up
	output logic [AXES*VAL_W-1:0]      m_tdata,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]           cfg_wdata
);

	logic [CFG_W-1:0] prop_q, integ_q, deriv_q;
	logic             busy_q;
	logic [AXES-1:0]  done;
	logic [AXES-1:0][VAL_W-1:0] drv;
	logic [AXES-1:0][VAL_W-1:0] res;
	logic             full;
	logic             acc;
	lane_ctl_t        ctl;
	logic [DT_W-1:0]  dt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			integ_q <= '0;
			deriv_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PROP:  prop_q  <= cfg_wdata;
				REG_INTEG: integ_q <= cfg_wdata;
				REG_DERIV: deriv_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign s_tready = !busy_q && !full;
	assign acc      = s_tvalid && s_tready;
	assign ctl      = '{start: acc, clear: (s_tuser == OP_CLEAR)};
	assign dt       = s_tdata[2*AXES*VAL_W +: DT_W];

	// The lanes run as one; busy covers the whole of a word's work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (acc)
			busy_q <= 1'b1;
		else if (done[0])
			busy_q <= 1'b0;
	end

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		logic [GAIN_W-1:0] kp, ki, kd;
		// Only four gains fit the registers; further axes run with zero gains.
		if (a < GAIN_SLOTS) begin : g_g
			assign kp = prop_q[a*GAIN_W +: GAIN_W];
			assign ki = integ_q[a*GAIN_W +: GAIN_W];
			assign kd = deriv_q[a*GAIN_W +: GAIN_W];
		end else begin : g_z
			assign kp = '0;
			assign ki = '0;
			assign kd = '0;
		end
		pfap_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ref_val  (s_tdata[a*VAL_W +: VAL_W]),
			.meas_val (s_tdata[(AXES+a)*VAL_W +: VAL_W]),
			.dt       (dt),
			.kp       (kp),
			.ki       (ki),
			.kd       (kd),
			.done     (done[a]),
			.drive    (drv[a])
		);
	end

	pfap_merge #(.AXES(AXES)) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.lane_done  (done),
		.lane_drive (drv),
		.take       (m_tready),
		.full       (full),
		.result     (res)
	);

	assign m_tvalid = full;
	assign m_tdata  = res;

endmodule
